@@ src/pcd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcd_pkg
// Shared types and constants of the path pair conflict detector.
// ----------------------------------------------------------------------------
package pcd_pkg;

	localparam int PCD_MAX_PATH_LEN = 1024;
	localparam int PCD_CELL_BITS    = 16;

	localparam int ACTION_W   = 2;
	localparam int CELL_REQ_W = 16;
	localparam int AGENT_W    = 10;
	localparam int CELL_OUT_W = 16;
	localparam int WHEN_W     = 11;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// word index of the only register
	localparam logic [APB_ADDR_W-3:0] REG_TARGET_MODE = '0;

	typedef enum logic [ACTION_W-1:0] {
		ACT_APPEND_FIRST  = 2'd0,
		ACT_APPEND_SECOND = 2'd1,
		ACT_CHECK         = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_VERTEX = 2'd1,
		KIND_EDGE   = 2'd2,
		KIND_TARGET = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_TAIL,
		S_COMMON,
		S_DONE
	} scan_state_t;

	typedef struct packed {
		logic [AGENT_W-1:0] first_agent;
		logic [AGENT_W-1:0] second_agent;
		logic               target_mode;
		logic               overflowed;
	} pcd_check_t;

	typedef struct packed {
		kind_t                 kind;
		logic [AGENT_W-1:0]    agent_one;
		logic [AGENT_W-1:0]    agent_two;
		logic [CELL_OUT_W-1:0] where_one;
		logic [CELL_OUT_W-1:0] where_two;
		logic [WHEN_W-1:0]     when;
		logic                  overflowed;
	} pcd_result_t;

	// handshake between top level and scan sequencer
	typedef struct packed {
		logic start;
		logic res_ready;
	} scan_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} scan_stat_t;

endpackage

@@ src/pcd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcd_if
// Request and result channels of the path pair conflict detector.
// ----------------------------------------------------------------------------
interface pcd_req_if import pcd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [ACTION_W-1:0]   action;
	logic [CELL_REQ_W-1:0] cell_req;
	logic [AGENT_W-1:0]    first_agent;
	logic [AGENT_W-1:0]    second_agent;

	modport source (output valid, action, cell_req, first_agent, second_agent, input ready);
	modport sink (input valid, action, cell_req, first_agent, second_agent, output ready);
endinterface

interface pcd_res_if import pcd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [1:0]            kind;
	logic [AGENT_W-1:0]    agent_one;
	logic [AGENT_W-1:0]    agent_two;
	logic [CELL_OUT_W-1:0] where_one;
	logic [CELL_OUT_W-1:0] where_two;
	logic [WHEN_W-1:0]     when;
	logic                  overflowed;

	modport source (output valid, kind, agent_one, agent_two, where_one, where_two, when,
		overflowed, input ready);
	modport sink (input valid, kind, agent_one, agent_two, where_one, where_two, when,
		overflowed, output ready);
endinterface

@@ src/pcd_path_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcd_path_mem
// One path store: single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module pcd_path_mem #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ src/pcd_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcd_scan
// Check sequencer: walks both path stores and forms the first conflict.
// ----------------------------------------------------------------------------
module pcd_scan import pcd_pkg::*; #(
	parameter int MAX_PATH_LEN = PCD_MAX_PATH_LEN,
	parameter int CELL_BITS    = PCD_CELL_BITS,
	localparam int LEN_W       = $clog2(MAX_PATH_LEN + 1),
	localparam int ADDR_W      = $clog2(MAX_PATH_LEN)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  scan_ctrl_t        ctrl,
	output scan_stat_t        stat,
	input  pcd_check_t        chk,
	input  logic [LEN_W-1:0]  n1,
	input  logic [LEN_W-1:0]  n2,
	output logic              rd_en,
	output logic [ADDR_W-1:0] addr_a,
	output logic [ADDR_W-1:0] addr_b,
	input  logic [CELL_BITS-1:0] rdata_a,
	input  logic [CELL_BITS-1:0] rdata_b,
	output pcd_result_t       res
);

	scan_state_t          state_q, state_d;
	logic [LEN_W-1:0]     t_q, t_d;
	logic                 v_s1, v_d;
	logic [LEN_W-1:0]     idx_s1;
	logic [CELL_BITS-1:0] prev_a_q, prev_b_q;
	pcd_result_t          res_q, res_d;

	logic [LEN_W-1:0]     n1_q, n2_q, common_q, long_len_q;
	logic                 first_short_q;
	pcd_check_t           chk_q;

	logic [LEN_W-1:0]     com;
	logic [LEN_W-1:0]     goal_idx;
	logic [LEN_W-1:0]     idx_next;
	logic [CELL_BITS-1:0] long_data, short_data;
	logic                 issue;

	assign com        = (n1 < n2) ? n1 : n2;
	assign goal_idx   = common_q - LEN_W'(1);
	assign idx_next   = idx_s1 + LEN_W'(1);
	assign long_data  = first_short_q ? rdata_b : rdata_a;
	assign short_data = first_short_q ? rdata_a : rdata_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			v_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		t_q    <= t_d;
		idx_s1 <= t_q;
		res_q  <= res_d;
		if (v_s1) begin
			prev_a_q <= rdata_a;
			prev_b_q <= rdata_b;
		end
		if (state_q == S_IDLE && ctrl.start) begin
			n1_q          <= n1;
			n2_q          <= n2;
			common_q      <= com;
			long_len_q    <= (n1 < n2) ? n2 : n1;
			first_short_q <= n1 < n2;
			chk_q         <= chk;
		end
	end

	always_comb begin
		state_d = state_q;
		t_d     = t_q;
		res_d   = res_q;
		issue   = 1'b0;
		rd_en   = 1'b0;
		addr_a  = t_q[ADDR_W-1:0];
		addr_b  = t_q[ADDR_W-1:0];
		stat.busy = state_q != S_IDLE;
		stat.done = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (ctrl.start) begin
					res_d            = '0;
					res_d.overflowed = chk.overflowed;
					t_d              = '0;
					state_d          = S_DONE;
					if (n1 != n2 && com != '0) begin
						state_d = S_TAIL;
						t_d     = com;
					end else if (com != '0) begin
						state_d = S_COMMON;
					end
				end
			end

			S_TAIL: begin
				// short path re-reads its final cell every cycle
				if (t_q < long_len_q) begin
					issue  = 1'b1;
					rd_en  = 1'b1;
					addr_a = first_short_q ? goal_idx[ADDR_W-1:0] : t_q[ADDR_W-1:0];
					addr_b = first_short_q ? t_q[ADDR_W-1:0] : goal_idx[ADDR_W-1:0];
					t_d    = t_q + LEN_W'(1);
				end
				if (v_s1) begin
					if (long_data == short_data) begin
						res_d.kind      = chk_q.target_mode ? KIND_TARGET : KIND_VERTEX;
						res_d.agent_one = first_short_q ? chk_q.first_agent : chk_q.second_agent;
						res_d.agent_two = first_short_q ? chk_q.second_agent : chk_q.first_agent;
						res_d.where_one = CELL_OUT_W'(short_data);
						res_d.when      = WHEN_W'(idx_s1);
						state_d         = S_DONE;
						issue           = 1'b0;
					end else if (idx_next == long_len_q) begin
						state_d = S_COMMON;
						t_d     = '0;
						issue   = 1'b0;
					end
				end
			end

			S_COMMON: begin
				if (t_q < common_q) begin
					issue = 1'b1;
					rd_en = 1'b1;
					t_d   = t_q + LEN_W'(1);
				end
				if (v_s1) begin
					// swap between previous step and this one ranks before a vertex here
					if (idx_s1 != '0 && prev_a_q == rdata_b && prev_b_q == rdata_a) begin
						res_d.kind      = KIND_EDGE;
						res_d.agent_one = chk_q.first_agent;
						res_d.agent_two = chk_q.second_agent;
						res_d.where_one = CELL_OUT_W'(prev_a_q);
						res_d.where_two = CELL_OUT_W'(prev_b_q);
						res_d.when      = WHEN_W'(idx_s1);
						state_d         = S_DONE;
						issue           = 1'b0;
					end else if (rdata_a == rdata_b) begin
						res_d.where_one = CELL_OUT_W'(rdata_a);
						res_d.when      = WHEN_W'(idx_s1);
						res_d.kind      = KIND_VERTEX;
						res_d.agent_one = chk_q.first_agent;
						res_d.agent_two = chk_q.second_agent;
						if (chk_q.target_mode && n1_q == idx_next) begin
							res_d.kind = KIND_TARGET;
						end else if (chk_q.target_mode && n2_q == idx_next) begin
							res_d.kind      = KIND_TARGET;
							res_d.agent_one = chk_q.second_agent;
							res_d.agent_two = chk_q.first_agent;
						end
						state_d = S_DONE;
						issue   = 1'b0;
					end else if (idx_next == common_q) begin
						state_d = S_DONE;
						issue   = 1'b0;
					end
				end
			end

			S_DONE: begin
				stat.done = 1'b1;
				if (ctrl.res_ready) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase

		v_d = issue;
	end

	assign res = res_q;

endmodule

@@ src/path_pair_conflict_detect.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_pair_conflict_detect
// Loads two timed paths into on-chip stores and reports their first conflict.
// ----------------------------------------------------------------------------
//
//  port   | dir | handshake        | carries
//  -------+-----+------------------+----------------------------------------
//  req    | in  | valid / ready    | action, cell_req, first/second_agent
//  res    | out | valid / ready    | kind, agents, where_one/two, when, ovf
//  apb    | in  | psel/penable     | target_mode at word 0
//
//  Appends are taken back to back. A check request holds off req while the
//  scan runs (no tail or bubble at equal lengths, no reads if a path is
//  empty): one read per step of the longer path through the single read
//  port of each store, a bubble where the tail search hands over to the
//  common steps, the registered read, then the hand-off to the output
//  register. A hit ends the scan early. Reset clears lengths, overflow
//  flag, target_mode and all control; the path stores are not cleared
//  (only entries written since the last check are ever read). A result
//  stalled on res does not block appends; a later check finishes its
//  scan and then holds req off until the output frees.
//
module path_pair_conflict_detect import pcd_pkg::*; #(
	parameter int MAX_PATH_LEN = PCD_MAX_PATH_LEN,
	parameter int CELL_BITS    = PCD_CELL_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	pcd_req_if.sink               req,
	pcd_res_if.source             res
);

	localparam int LEN_W  = $clog2(MAX_PATH_LEN + 1);
	localparam int ADDR_W = $clog2(MAX_PATH_LEN);

	// configuration register
	logic target_mode_q;
	logic reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = paddr[APB_ADDR_W-1:2] == REG_TARGET_MODE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && reg_hit) begin
			target_mode_q <= pwdata[0];
		end
	end

	assign prdata = reg_hit ? APB_DATA_W'(target_mode_q) : '0;

	// request decode
	scan_ctrl_t           ctrl;
	scan_stat_t           stat;
	pcd_check_t           chk;
	pcd_result_t          scan_res;
	logic                 req_acc;
	logic                 app1, app2, check;
	logic [CELL_BITS-1:0] cell_in;

	logic [LEN_W-1:0]     len1_q, len2_q;
	logic                 ovf_q;
	logic                 full1, full2;

	assign req.ready = !stat.busy;
	assign req_acc   = req.valid && req.ready;
	assign cell_in   = CELL_BITS'(req.cell_req);
	assign full1     = len1_q == LEN_W'(MAX_PATH_LEN);
	assign full2     = len2_q == LEN_W'(MAX_PATH_LEN);

	always_comb begin
		app1  = 1'b0;
		app2  = 1'b0;
		check = 1'b0;
		unique case (action_t'(req.action))
			ACT_APPEND_FIRST:  app1  = req_acc;
			ACT_APPEND_SECOND: app2  = req_acc;
			ACT_CHECK:         check = req_acc;
			default: ;
		endcase
	end

	// lengths and overflow; a check hands the old values to the scan and clears them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len1_q <= '0;
			len2_q <= '0;
			ovf_q  <= 1'b0;
		end else if (check) begin
			len1_q <= '0;
			len2_q <= '0;
			ovf_q  <= 1'b0;
		end else begin
			if (app1) begin
				if (full1) begin
					ovf_q <= 1'b1;
				end else begin
					len1_q <= len1_q + LEN_W'(1);
				end
			end
			if (app2) begin
				if (full2) begin
					ovf_q <= 1'b1;
				end else begin
					len2_q <= len2_q + LEN_W'(1);
				end
			end
		end
	end

	assign chk.first_agent  = req.first_agent;
	assign chk.second_agent = req.second_agent;
	assign chk.target_mode  = target_mode_q;
	assign chk.overflowed   = ovf_q;

	// path stores; no append is taken while the scan reads them
	logic                 rd_en;
	logic [ADDR_W-1:0]    addr_a, addr_b;
	logic [CELL_BITS-1:0] rdata_a, rdata_b;

	pcd_path_mem #(
		.DEPTH (MAX_PATH_LEN),
		.WIDTH (CELL_BITS)
	) u_mem_first (
		.clk   (clk),
		.we    (app1 && !full1),
		.waddr (len1_q[ADDR_W-1:0]),
		.wdata (cell_in),
		.re    (rd_en),
		.raddr (addr_a),
		.rdata (rdata_a)
	);

	pcd_path_mem #(
		.DEPTH (MAX_PATH_LEN),
		.WIDTH (CELL_BITS)
	) u_mem_second (
		.clk   (clk),
		.we    (app2 && !full2),
		.waddr (len2_q[ADDR_W-1:0]),
		.wdata (cell_in),
		.re    (rd_en),
		.raddr (addr_b),
		.rdata (rdata_b)
	);

	// scan sequencer
	logic        res_valid_q;
	pcd_result_t res_q;
	logic        out_free;

	assign out_free       = !res_valid_q || res.ready;
	assign ctrl.start     = check;
	assign ctrl.res_ready = out_free;

	pcd_scan #(
		.MAX_PATH_LEN (MAX_PATH_LEN),
		.CELL_BITS    (CELL_BITS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.stat    (stat),
		.chk     (chk),
		.n1      (len1_q),
		.n2      (len2_q),
		.rd_en   (rd_en),
		.addr_a  (addr_a),
		.addr_b  (addr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b),
		.res     (scan_res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (stat.done && out_free) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done && out_free) begin
			res_q <= scan_res;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.kind       = res_q.kind;
	assign res.agent_one  = res_q.agent_one;
	assign res.agent_two  = res_q.agent_two;
	assign res.where_one  = res_q.where_one;
	assign res.where_two  = res_q.where_two;
	assign res.when       = res_q.when;
	assign res.overflowed = res_q.overflowed;

endmodule

@@ src/pcd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcd_checker
// Port-level checks of the path pair conflict detector, bound to the top.
// ----------------------------------------------------------------------------
module pcd_checker import pcd_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_ready,
	input logic [ACTION_W-1:0]   req_action,
	input logic                  res_valid,
	input logic                  res_ready,
	input logic [1:0]            res_kind,
	input logic [AGENT_W-1:0]    res_agent_one,
	input logic [AGENT_W-1:0]    res_agent_two,
	input logic [CELL_OUT_W-1:0] res_where_one,
	input logic [CELL_OUT_W-1:0] res_where_two,
	input logic [WHEN_W-1:0]     res_when
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_busy_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_action == ACT_CHECK |=> !req_ready)
		else $error("request taken right after a check");

	a_result_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> !$past(req_ready))
		else $error("result appeared without a scan");

	a_none_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == KIND_NONE |-> res_agent_one == '0 && res_agent_two == '0
			&& res_where_one == '0 && res_where_two == '0 && res_when == '0)
		else $error("no-conflict result carries data");

	a_where_two_edge_only: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind != KIND_EDGE |-> res_where_two == '0)
		else $error("second cell set on a non-edge result");

endmodule

bind path_pair_conflict_detect pcd_checker u_pcd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_action    (req.action),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.res_kind      (res.kind),
	.res_agent_one (res.agent_one),
	.res_agent_two (res.agent_two),
	.res_where_one (res.where_one),
	.res_where_two (res.where_two),
	.res_when      (res.when)
);
